// ===== design/flhs_pkg.sv =====
// types, constants and helper functions shared by the luma histogram statistics block
package flhs_pkg;

  localparam int SizeW            = 13;
  localparam int MaxWidthDefault  = 4096;
  localparam int MaxHeightDefault = 4096;
  localparam int LumaW            = 8;
  localparam int HistBins         = 256;
  localparam int HistW            = 25;
  localparam int SumW             = 32;
  localparam int DetailW          = 33;
  localparam int PairW            = 26;
  localparam int PixelW           = 25;
  localparam int LumaAccW         = 24;

  localparam logic [SizeW-1:0] WidthReset  = 13'd640;
  localparam logic [SizeW-1:0] HeightReset = 13'd480;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_BIN   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic KIND_TOTALS = 1'b0;
  localparam logic KIND_BIN    = 1'b1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [LumaW-1:0] red;
    logic [LumaW-1:0] green;
    logic [LumaW-1:0] blue;
    logic [LumaW-1:0] bin_index;
  } item_t;

  typedef struct packed {
    logic               result_kind;
    logic [SumW-1:0]    red_total;
    logic [SumW-1:0]    green_total;
    logic [SumW-1:0]    blue_total;
    logic [SumW-1:0]    chroma_total;
    logic [DetailW-1:0] detail_total;
    logic [PairW-1:0]   pair_count;
    logic [PixelW-1:0]  pixel_total;
    logic [HistW-1:0]   bin_count;
  } result_t;

  // rec709 luma, 16-bit fraction, rounded
  function automatic logic [LumaW-1:0] luma_of(input logic [LumaW-1:0] r,
                                                input logic [LumaW-1:0] g,
                                                input logic [LumaW-1:0] b);
    logic [LumaAccW-1:0] acc;
    acc = LumaAccW'(r) * 24'd13933 + LumaAccW'(g) * 24'd46871
        + LumaAccW'(b) * 24'd4732 + 24'd32768;
    return acc[LumaAccW-1:LumaAccW-LumaW];
  endfunction

  function automatic logic [LumaW-1:0] abs_diff(input logic [LumaW-1:0] a,
                                                 input logic [LumaW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

// ===== design/flhs_ram.sv =====
// generic single-write, single-read ram with registered read data
module flhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/frame_luma_histogram_statistics.sv =====
// top level of the frame luma histogram and image statistics block
// a pixel or bin read beat is accepted in idle, reads the memories in the fetch state and updates
// in the update state, where any result it emits is registered
// no new beat is taken until a pixel or bin read beat has updated; clear and ignored beats stay in idle;
// a waiting result holds the update stage only if the beat must emit
// synchronous reset clears all totals, positions and histogram valid bits and loads 640 by 480
module frame_luma_histogram_statistics #(
  parameter int MAX_WIDTH  = flhs_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = flhs_pkg::MaxHeightDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  flhs_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output flhs_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [flhs_pkg::SizeW-1:0] cfg_data
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);
  localparam int CmpA = (ColW > RowW) ? ColW + 1 : RowW + 1;
  localparam int CmpW = (CmpA > flhs_pkg::SizeW) ? CmpA : flhs_pkg::SizeW;
  localparam int LumaW = flhs_pkg::LumaW;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_FETCH  = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state;

  logic [flhs_pkg::SizeW-1:0]   frame_width;
  logic [flhs_pkg::SizeW-1:0]   frame_height;
  flhs_pkg::item_t              cur;
  logic [LumaW-1:0]             luma;
  logic [LumaW-1:0]             hist_addr;
  logic [flhs_pkg::HistBins-1:0] hist_valid;
  logic [LumaW-1:0]             left_luma;
  logic [ColW-1:0]              col;
  logic [RowW-1:0]              row;
  logic [flhs_pkg::SumW-1:0]    red_sum;
  logic [flhs_pkg::SumW-1:0]    green_sum;
  logic [flhs_pkg::SumW-1:0]    blue_sum;
  logic [flhs_pkg::SumW-1:0]    chroma_sum;
  logic [flhs_pkg::DetailW-1:0] detail_sum;
  logic [flhs_pkg::PairW-1:0]   pairs_seen;
  logic [flhs_pkg::PixelW-1:0]  pixels_seen;
  logic                         frame_done;

  logic                         accept;
  logic [LumaW-1:0]             luma_calc;
  logic [LumaW-1:0]             hist_rd_addr;
  logic [flhs_pkg::HistW-1:0]   hist_rd_data;
  logic [flhs_pkg::HistW-1:0]   hist_old;
  logic [flhs_pkg::HistW-1:0]   hist_new;
  logic [LumaW-1:0]             line_rd_data;
  logic                         mem_wr_en;
  logic [CmpW-1:0]              w_raw;
  logic [CmpW-1:0]              h_raw;
  logic [CmpW-1:0]              w_eff;
  logic [CmpW-1:0]              h_eff;
  logic [CmpW-1:0]              col_inc;
  logic [CmpW-1:0]              row_inc;
  logic                         row_end;
  logic                         frame_end;
  logic [LumaW-1:0]             hi;
  logic [LumaW-1:0]             lo;
  logic [LumaW-1:0]             left_diff;
  logic [LumaW-1:0]             up_diff;
  logic [flhs_pkg::SumW-1:0]    red_next;
  logic [flhs_pkg::SumW-1:0]    green_next;
  logic [flhs_pkg::SumW-1:0]    blue_next;
  logic [flhs_pkg::SumW-1:0]    chroma_next;
  logic [flhs_pkg::DetailW-1:0] detail_next;
  logic [flhs_pkg::PairW-1:0]   pairs_next;
  logic [flhs_pkg::PixelW-1:0]  pixels_next;
  flhs_pkg::result_t            result_next;
  logic                         is_bin;
  logic                         produce;
  logic                         out_free;
  logic                         go;
  logic                         emit;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  assign luma_calc    = flhs_pkg::luma_of(cur.red, cur.green, cur.blue);
  assign is_bin       = (cur.operation == flhs_pkg::OP_BIN);
  assign hist_rd_addr = is_bin ? cur.bin_index : luma_calc;

  flhs_ram #(
    .WIDTH (flhs_pkg::HistW),
    .DEPTH (flhs_pkg::HistBins)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (hist_addr),
    .wr_data (hist_new),
    .rd_en   (state == S_FETCH),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd_data)
  );

  flhs_ram #(
    .WIDTH (LumaW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (col),
    .wr_data (luma),
    .rd_en   (state == S_FETCH),
    .rd_addr (col),
    .rd_data (line_rd_data)
  );

  // size limits: zero counts as one, oversize counts as the maximum
  always_comb begin
    w_raw = CmpW'(frame_width);
    h_raw = CmpW'(frame_height);
    priority if (w_raw == '0) begin
      w_eff = CmpW'(1);
    end else if (w_raw > CmpW'(MAX_WIDTH)) begin
      w_eff = CmpW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    priority if (h_raw == '0) begin
      h_eff = CmpW'(1);
    end else if (h_raw > CmpW'(MAX_HEIGHT)) begin
      h_eff = CmpW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  assign col_inc   = CmpW'(col) + CmpW'(1);
  assign row_inc   = CmpW'(row) + CmpW'(1);
  assign row_end   = (col_inc >= w_eff);
  assign frame_end = row_end && (row_inc >= h_eff);

  always_comb begin
    hi = cur.red;
    lo = cur.red;
    if (cur.green > hi) begin
      hi = cur.green;
    end
    if (cur.blue > hi) begin
      hi = cur.blue;
    end
    if (cur.green < lo) begin
      lo = cur.green;
    end
    if (cur.blue < lo) begin
      lo = cur.blue;
    end
  end

  assign left_diff = (col != '0) ? flhs_pkg::abs_diff(left_luma, luma) : '0;
  assign up_diff   = (row != '0) ? flhs_pkg::abs_diff(line_rd_data, luma) : '0;

  assign hist_old    = hist_valid[hist_addr] ? hist_rd_data : '0;
  assign hist_new    = hist_old + flhs_pkg::HistW'(1);
  assign red_next    = red_sum + flhs_pkg::SumW'(cur.red);
  assign green_next  = green_sum + flhs_pkg::SumW'(cur.green);
  assign blue_next   = blue_sum + flhs_pkg::SumW'(cur.blue);
  assign chroma_next = chroma_sum + flhs_pkg::SumW'(hi - lo);
  assign detail_next = detail_sum + flhs_pkg::DetailW'(left_diff)
                     + flhs_pkg::DetailW'(up_diff);
  assign pairs_next  = pairs_seen + flhs_pkg::PairW'(col != '0)
                     + flhs_pkg::PairW'(row != '0);
  assign pixels_next = pixels_seen + flhs_pkg::PixelW'(1);

  assign produce   = is_bin || frame_end;
  assign out_free  = !result_valid || !result_stall;
  assign go        = !produce || out_free;
  assign emit      = (state == S_UPDATE) && go && produce;
  assign mem_wr_en = (state == S_UPDATE) && go && !is_bin;

  always_comb begin
    result_next = '0;
    if (is_bin) begin
      result_next.result_kind = flhs_pkg::KIND_BIN;
      result_next.bin_count   = hist_old;
    end else begin
      result_next.result_kind  = flhs_pkg::KIND_TOTALS;
      result_next.red_total    = red_next;
      result_next.green_total  = green_next;
      result_next.blue_total   = blue_next;
      result_next.chroma_total = chroma_next;
      result_next.detail_total = detail_next;
      result_next.pair_count   = pairs_next;
      result_next.pixel_total  = pixels_next;
    end
  end

  // control and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= flhs_pkg::WidthReset;
      frame_height <= flhs_pkg::HeightReset;
      hist_valid   <= '0;
      left_luma    <= '0;
      col          <= '0;
      row          <= '0;
      red_sum      <= '0;
      green_sum    <= '0;
      blue_sum     <= '0;
      chroma_sum   <= '0;
      detail_sum   <= '0;
      pairs_seen   <= '0;
      pixels_seen  <= '0;
      frame_done   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          flhs_pkg::REG_WIDTH:  frame_width  <= cfg_data;
          flhs_pkg::REG_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end

      result_valid <= emit || (result_valid && result_stall);

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (item.operation == flhs_pkg::OP_CLEAR) begin
              hist_valid  <= '0;
              left_luma   <= '0;
              col         <= '0;
              row         <= '0;
              red_sum     <= '0;
              green_sum   <= '0;
              blue_sum    <= '0;
              chroma_sum  <= '0;
              detail_sum  <= '0;
              pairs_seen  <= '0;
              pixels_seen <= '0;
              frame_done  <= 1'b0;
            end else if (item.operation == flhs_pkg::OP_BIN) begin
              state <= S_FETCH;
            end else if (item.operation == flhs_pkg::OP_PIXEL && !frame_done) begin
              state <= S_FETCH;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FETCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (go) begin
            state <= S_IDLE;
            if (!is_bin) begin
              hist_valid[hist_addr] <= 1'b1;
              left_luma   <= luma;
              red_sum     <= red_next;
              green_sum   <= green_next;
              blue_sum    <= blue_next;
              chroma_sum  <= chroma_next;
              detail_sum  <= detail_next;
              pairs_seen  <= pairs_next;
              pixels_seen <= pixels_next;
              if (row_end) begin
                col <= '0;
                if (frame_end) begin
                  frame_done <= 1'b1;
                end else begin
                  row <= row_inc[RowW-1:0];
                end
              end else begin
                col <= col_inc[ColW-1:0];
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    if (state == S_FETCH) begin
      luma      <= luma_calc;
      hist_addr <= hist_rd_addr;
    end
    if (emit) begin
      result <= result_next;
    end
  end

endmodule
